// File: hw/rtl/fadj_pkg.sv
// ----------------------------------------------------------------------------
// fadj_pkg
// shared types, widths and defaults of the queue-servo frame adjuster
// ----------------------------------------------------------------------------
package fadj_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SIZE_W    = 16;
    localparam int LEVEL_W   = 13;
    localparam int LEN_W     = 13;
    localparam int COUNT_W   = 32;
    localparam int COPIES_W  = 2;
    localparam int CORR_W    = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 13;

    // parameter defaults
    localparam int MAX_BLOCK_DEF = 4096;
    localparam int WARMUP_DEF    = 120;
    localparam int POLL_DEF      = 16;
    localparam int STEP_DEF      = 2;

    // threshold reset values
    localparam logic [LEVEL_W-1:0] LOW_THR_RST  = 13'd2560;
    localparam logic [LEVEL_W-1:0] HIGH_THR_RST = 13'd3840;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 8'd1;

    // copies codes
    localparam logic [COPIES_W-1:0] COPIES_DROP = 2'd0;
    localparam logic [COPIES_W-1:0] COPIES_ONE  = 2'd1;
    localparam logic [COPIES_W-1:0] COPIES_DUP  = 2'd2;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_DUP  = 2'd1,
        ADJ_DROP = 2'd2
    } t_adj;

    // block setup handed from block control to the frame stepper
    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] len;
        t_adj             dir;
    } t_blk_cmd;

endpackage

// File: hw/rtl/fadj_block_ctl.sv
// ----------------------------------------------------------------------------
// fadj_block_ctl
// block counter, poll schedule and per-block adjustment decision
// ----------------------------------------------------------------------------
module fadj_block_ctl #(
    parameter int MAX_BLOCK = fadj_pkg::MAX_BLOCK_DEF,
    parameter int WARMUP    = fadj_pkg::WARMUP_DEF,
    parameter int POLL      = fadj_pkg::POLL_DEF,
    parameter int STEP      = fadj_pkg::STEP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_start,
    input  logic [fadj_pkg::SIZE_W-1:0]    i_size,
    input  logic [fadj_pkg::LEVEL_W-1:0]   i_level,
    input  logic                           i_level_valid,
    input  logic [fadj_pkg::LEVEL_W-1:0]   i_low_thr,
    input  logic [fadj_pkg::LEVEL_W-1:0]   i_high_thr,
    output fadj_pkg::t_blk_cmd             o_cmd
);
    import fadj_pkg::*;

    localparam int PollW = (POLL > 1) ? $clog2(POLL) : 1;

    logic [COUNT_W-1:0] r_block_count, n_block_count;
    logic [PollW-1:0]   r_poll_idx, n_poll_idx;

    logic             size_zero;
    logic [LEN_W-1:0] len;
    logic             poll_hit;
    logic             dup_ok;
    logic             drop_ok;
    t_adj             dir;

    always_comb begin
        size_zero = (i_size == '0);
        len = (i_size > SIZE_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : i_size[LEN_W-1:0];
        poll_hit = (r_block_count >= COUNT_W'(WARMUP)) && (r_poll_idx == '0)
                   && i_level_valid;
        dup_ok  = (len > LEN_W'(STEP))
                  && (({1'b0, len} + (LEN_W+1)'(STEP)) <= (LEN_W+1)'(MAX_BLOCK));
        drop_ok = (len > LEN_W'(STEP));

        dir = ADJ_NONE;
        if (poll_hit) begin
            priority if (i_level < i_low_thr) begin
                if (dup_ok) dir = ADJ_DUP;
            end else if (i_level > i_high_thr) begin
                if (drop_ok) dir = ADJ_DROP;
            end else begin
                // level inside the band
                dir = ADJ_NONE;
            end
        end

        o_cmd.load = i_start;
        o_cmd.len  = size_zero ? '0 : len;
        o_cmd.dir  = size_zero ? ADJ_NONE : dir;

        n_block_count = r_block_count;
        n_poll_idx    = r_poll_idx;
        if (i_fire && i_start && !size_zero) begin
            n_block_count = r_block_count + 1'b1;
            // counter wrap restarts the poll phase as the modulo would
            if (r_block_count == '1 || r_poll_idx == PollW'(POLL - 1)) begin
                n_poll_idx = '0;
            end else begin
                n_poll_idx = r_poll_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
            r_poll_idx    <= '0;
        end else begin
            r_block_count <= n_block_count;
            r_poll_idx    <= n_poll_idx;
        end
    end

    a_poll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_poll_idx <= PollW'(POLL - 1))
        else $error("poll index out of range");

endmodule

// File: hw/rtl/fadj_frame_step.sv
// ----------------------------------------------------------------------------
// fadj_frame_step
// bresenham phase accumulator deciding drop or duplicate per frame
// ----------------------------------------------------------------------------
module fadj_frame_step #(
    parameter int MAX_BLOCK = fadj_pkg::MAX_BLOCK_DEF,
    parameter int STEP      = fadj_pkg::STEP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  fadj_pkg::t_blk_cmd                   i_cmd,
    output logic [fadj_pkg::COPIES_W-1:0]        o_copies,
    output logic signed [fadj_pkg::CORR_W-1:0]   o_correction
);
    import fadj_pkg::*;

    localparam int CorrPos = (STEP > 3) ? 3 : STEP;
    localparam int CorrNeg = (STEP > 4) ? 4 : STEP;

    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_phase, n_phase;
    t_adj             r_dir, n_dir;

    logic [LEN_W-1:0] e_len, e_idx, e_phase;
    t_adj             e_dir;
    logic [LEN_W:0]   sum;
    logic             wrap;

    always_comb begin
        // state as seen after a block start on this frame
        if (i_cmd.load) begin
            e_len   = i_cmd.len;
            e_idx   = '0;
            e_phase = i_cmd.len >> 1;
            e_dir   = i_cmd.dir;
        end else begin
            e_len   = r_len;
            e_idx   = r_idx;
            e_phase = r_phase;
            e_dir   = r_dir;
        end

        sum  = {1'b0, e_phase} + (LEN_W+1)'(STEP);
        wrap = (sum >= {1'b0, e_len});

        n_len   = e_len;
        n_dir   = e_dir;
        n_idx   = e_idx;
        n_phase = e_phase;
        o_copies = COPIES_DROP;

        if (e_idx < e_len) begin
            n_idx    = e_idx + 1'b1;
            o_copies = COPIES_ONE;
            unique case (e_dir)
                ADJ_DUP: begin
                    n_phase = wrap ? LEN_W'(sum - {1'b0, e_len}) : sum[LEN_W-1:0];
                    if (wrap) o_copies = COPIES_DUP;
                end
                ADJ_DROP: begin
                    n_phase = wrap ? LEN_W'(sum - {1'b0, e_len}) : sum[LEN_W-1:0];
                    if (wrap) o_copies = COPIES_DROP;
                end
                default: ;
            endcase
        end

        unique case (e_dir)
            ADJ_DUP:  o_correction = CORR_W'(CorrPos);
            ADJ_DROP: o_correction = CORR_W'(-CorrNeg);
            default:  o_correction = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_idx   <= '0;
            r_phase <= '0;
            r_dir   <= ADJ_NONE;
        end else if (i_fire) begin
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_dir   <= n_dir;
        end
    end

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= LEN_W'(MAX_BLOCK)) && (r_idx <= r_len))
        else $error("block length or frame index out of range");

    a_phase_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) || (r_phase < r_len))
        else $error("phase accumulator not below block length");

endmodule

// File: hw/rtl/audio_queue_servo_frame_adjust_unit.sv
// ----------------------------------------------------------------------------
// audio_queue_servo_frame_adjust_unit
// queue-servo frame adjuster: drops or duplicates stereo frames per block
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall): one stereo frame per word; the
//   word with block_start high carries block size, queue level and its valid
//   flag. output channel (o_out_valid / i_out_stall): one result word per
//   input word with the samples, a copies count (0, 1 or 2) and the signed
//   correction of the current block.
//   config channel (i_cfg_valid / o_cfg_ready): index 0 low threshold,
//   index 1 high threshold; other indexes are ignored. write only while idle.
// dataflow and throughput
//   a word is held in the input register and is processed while it
//   moves into the result register, from which its result is offered.
//   one word per cycle sustained while the result is not stalled: the
//   phase accumulator is a single combinational add-and-compare loop.
// reset
//   synchronous active-low; clears both stages, block count, accumulator and
//   thresholds back to their defaults. no clearing pass is needed.
// stall
//   a stalled result holds; the input register still fills, and o_in_stall
//   rises only when both registers hold words.
// ----------------------------------------------------------------------------
module audio_queue_servo_frame_adjust_unit #(
    parameter int MAX_BLOCK = fadj_pkg::MAX_BLOCK_DEF,
    parameter int WARMUP    = fadj_pkg::WARMUP_DEF,
    parameter int POLL      = fadj_pkg::POLL_DEF,
    parameter int STEP      = fadj_pkg::STEP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input word channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fadj_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [fadj_pkg::SAMPLE_W-1:0] i_right_in,
    input  logic                                 i_block_start,
    input  logic [fadj_pkg::SIZE_W-1:0]          i_block_size,
    input  logic [fadj_pkg::LEVEL_W-1:0]         i_queue_level,
    input  logic                                 i_level_valid,
    // result word channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fadj_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [fadj_pkg::SAMPLE_W-1:0] o_right_out,
    output logic [fadj_pkg::COPIES_W-1:0]        o_copies,
    output logic signed [fadj_pkg::CORR_W-1:0]   o_correction,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fadj_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fadj_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import fadj_pkg::*;

    // thresholds
    logic [LEVEL_W-1:0] r_low_thr;
    logic [LEVEL_W-1:0] r_high_thr;

    // input register
    logic                        r_in_vld;
    logic signed [SAMPLE_W-1:0]  r_in_left;
    logic signed [SAMPLE_W-1:0]  r_in_right;
    logic                        r_in_start;
    logic [SIZE_W-1:0]           r_in_size;
    logic [LEVEL_W-1:0]          r_in_level;
    logic                        r_in_lvl_ok;

    // result register
    logic                        r_out_vld;
    logic signed [SAMPLE_W-1:0]  r_out_left;
    logic signed [SAMPLE_W-1:0]  r_out_right;
    logic [COPIES_W-1:0]         r_out_copies;
    logic signed [CORR_W-1:0]    r_out_corr;

    logic                        advance;   // result register may load
    logic                        in_load;   // input register may load
    logic                        fire;      // input word moves to results
    t_blk_cmd                    blk_cmd;
    logic [COPIES_W-1:0]         copies;
    logic signed [CORR_W-1:0]    corr;

    assign advance    = !r_out_vld || !i_out_stall;
    assign in_load    = !r_in_vld || advance;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = !in_load;
    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= LOW_THR_RST;
            r_high_thr <= HIGH_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_LOW_THRESHOLD)  r_low_thr  <= i_cfg_data;
            if (i_cfg_index == REG_HIGH_THRESHOLD) r_high_thr <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_load) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_left   <= i_left_in;
            r_in_right  <= i_right_in;
            r_in_start  <= i_block_start;
            r_in_size   <= i_block_size;
            r_in_level  <= i_queue_level;
            r_in_lvl_ok <= i_level_valid;
        end
    end

    // block decision
    fadj_block_ctl #(
        .MAX_BLOCK (MAX_BLOCK),
        .WARMUP    (WARMUP),
        .POLL      (POLL),
        .STEP      (STEP)
    ) u_block_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_start       (r_in_start),
        .i_size        (r_in_size),
        .i_level       (r_in_level),
        .i_level_valid (r_in_lvl_ok),
        .i_low_thr     (r_low_thr),
        .i_high_thr    (r_high_thr),
        .o_cmd         (blk_cmd)
    );

    // per-frame drop/duplicate
    fadj_frame_step #(
        .MAX_BLOCK (MAX_BLOCK),
        .STEP      (STEP)
    ) u_frame_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cmd        (blk_cmd),
        .o_copies     (copies),
        .o_correction (corr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_left   <= r_in_left;
            r_out_right  <= r_in_right;
            r_out_copies <= copies;
            r_out_corr   <= corr;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_left_out   = r_out_left;
    assign o_right_out  = r_out_right;
    assign o_copies     = r_out_copies;
    assign o_correction = r_out_corr;

    a_dup_needs_pos_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_copies == COPIES_DUP)) |-> (o_correction > 0))
        else $error("duplicated frame without positive correction");

    a_in_holds_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> r_in_vld)
        else $error("input word lost while result stage blocked");

endmodule
